### rtl/core/rmbp_pkg.sv
// Shared types and constants for the RESP multibulk request parser.
`timescale 1ns / 1ps

package rmbp_pkg;

  // Characters of the request grammar.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Decimal values at or above this bound are an overflow.
  localparam logic [63:0] NUM_CEIL = 64'd100000000;

  // Reset value of the length limit register.
  localparam logic [31:0] LIMIT_RESET_FULL = 32'd99999999;

  // Parse phase.
  typedef enum logic [3:0] {
    PH_ARR_LEAD = 4'd0,
    PH_ARR_NUM  = 4'd1,
    PH_ARR_LF   = 4'd2,
    PH_STR_LEAD = 4'd3,
    PH_STR_NUM  = 4'd4,
    PH_STR_LF   = 4'd5,
    PH_PAYLOAD  = 4'd6,
    PH_TAIL_CR  = 4'd7,
    PH_TAIL_LF  = 4'd8,
    PH_ERROR    = 4'd9
  } phase_t;

  // Event produced for each input word.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_COUNT   = 3'd1,
    EV_LENGTH  = 3'd2,
    EV_BYTE    = 3'd3,
    EV_STRING  = 3'd4,
    EV_MESSAGE = 3'd5,
    EV_ERROR   = 3'd6
  } event_t;

  // Small flags that travel with each result.
  typedef struct packed {
    event_t event_res;
    logic   last_payload;
  } res_flags_t;

endpackage

### rtl/core/rmbp_digit.sv
// Decimal accumulator step: folds one digit into the running number with overflow detection.
`timescale 1ns / 1ps

module rmbp_digit import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = 27
) (
  input  logic [NUMBER_WIDTH-1:0] accum,
  input  logic                    over,
  input  logic [3:0]              digit,
  output logic [NUMBER_WIDTH-1:0] accum_next,
  output logic                    over_next
);

  localparam int VW = NUMBER_WIDTH + 4;

  logic [VW-1:0] ext;
  logic [VW-1:0] prod;
  logic [63:0]   prod_wide;
  logic          too_big;

  // accum * 10 + digit, built from two shifts.
  assign ext       = {4'b0, accum};
  assign prod      = (ext << 3) + (ext << 1) + VW'(digit);
  assign prod_wide = {{(64 - VW){1'b0}}, prod};
  assign too_big   = (prod_wide >= NUM_CEIL) || (prod[VW-1:NUMBER_WIDTH] != 4'b0);

  // Once overflowed, the accumulator holds its value.
  always_comb begin
    accum_next = accum;
    over_next  = over;
    if (!over) begin
      if (too_big) begin
        over_next = 1'b1;
      end else begin
        accum_next = prod[NUMBER_WIDTH-1:0];
      end
    end
  end

endmodule

### rtl/core/rmbp_core.sv
// Parse state registers and the per-word phase update with event generation.
`timescale 1ns / 1ps

module rmbp_core import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              data_byte,
  input  logic [NUMBER_WIDTH-1:0] length_limit,
  output res_flags_t              res_flags,
  output logic [NUMBER_WIDTH-1:0] res_number,
  output logic [7:0]              res_payload,
  output logic [NUMBER_WIDTH-1:0] res_index
);

  phase_t                  phase, phase_next;
  logic [NUMBER_WIDTH-1:0] number_accum, number_accum_next;
  logic                    number_over, number_over_next;
  logic [NUMBER_WIDTH-1:0] element_total, element_total_next;
  logic [NUMBER_WIDTH-1:0] element_index, element_index_next;
  logic [NUMBER_WIDTH-1:0] payload_left, payload_left_next;

  logic [NUMBER_WIDTH-1:0] dig_accum;
  logic                    dig_over;
  logic                    is_digit;
  logic                    number_ok;
  logic                    last_string;
  logic [NUMBER_WIDTH:0]   index_inc;
  logic                    bad;
  event_t                  ev;
  logic [NUMBER_WIDTH-1:0] num;
  logic [7:0]              pay;
  logic                    last;

  // Decimal digit folding.
  rmbp_digit #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_digit (
    .accum      (number_accum),
    .over       (number_over),
    .digit      (data_byte[3:0]),
    .accum_next (dig_accum),
    .over_next  (dig_over)
  );

  assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign number_ok   = !number_over && (number_accum <= length_limit);
  assign index_inc   = {1'b0, element_index} + {{NUMBER_WIDTH{1'b0}}, 1'b1};
  assign last_string = index_inc >= {1'b0, element_total};

  // Phase update and event selection for one word.
  always_comb begin
    phase_next         = phase;
    number_accum_next  = number_accum;
    number_over_next   = number_over;
    element_total_next = element_total;
    element_index_next = element_index;
    payload_left_next  = payload_left;
    bad  = 1'b0;
    ev   = EV_NONE;
    num  = '0;
    pay  = 8'h00;
    last = 1'b0;
    unique case (phase)
      PH_ARR_LEAD: begin
        element_index_next = '0;
        if (data_byte == CH_STAR) begin
          number_accum_next = '0;
          number_over_next  = 1'b0;
          phase_next        = PH_ARR_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ARR_NUM, PH_STR_NUM: begin
        if (data_byte == CH_CR) begin
          phase_next = (phase == PH_ARR_NUM) ? PH_ARR_LF : PH_STR_LF;
        end else if (is_digit) begin
          number_accum_next = dig_accum;
          number_over_next  = dig_over;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ARR_LF: begin
        if (data_byte != CH_LF || !number_ok) begin
          bad = 1'b1;
        end else begin
          element_total_next = number_accum;
          element_index_next = '0;
          if (number_accum == '0) begin
            ev         = EV_MESSAGE;
            phase_next = PH_ARR_LEAD;
          end else begin
            ev         = EV_COUNT;
            num        = number_accum;
            phase_next = PH_STR_LEAD;
          end
        end
      end
      PH_STR_LEAD: begin
        if (data_byte == CH_DOLLAR) begin
          number_accum_next = '0;
          number_over_next  = 1'b0;
          phase_next        = PH_STR_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      PH_STR_LF: begin
        if (data_byte != CH_LF || !number_ok) begin
          bad = 1'b1;
        end else begin
          payload_left_next = number_accum;
          ev                = EV_LENGTH;
          num               = number_accum;
          phase_next        = (number_accum == '0) ? PH_TAIL_CR : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev   = EV_BYTE;
        pay  = data_byte;
        last = (payload_left <= NUMBER_WIDTH'(1));
        if (last) begin
          payload_left_next = '0;
          phase_next        = PH_TAIL_CR;
        end else begin
          payload_left_next = payload_left - NUMBER_WIDTH'(1);
        end
      end
      PH_TAIL_CR: begin
        if (data_byte == CH_CR) begin
          phase_next = PH_TAIL_LF;
        end else begin
          bad = 1'b1;
        end
      end
      PH_TAIL_LF: begin
        if (data_byte != CH_LF) begin
          bad = 1'b1;
        end else if (last_string) begin
          ev         = EV_MESSAGE;
          phase_next = PH_ARR_LEAD;
        end else begin
          ev                 = EV_STRING;
          element_index_next = index_inc[NUMBER_WIDTH-1:0];
          phase_next         = PH_STR_LEAD;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    // Any violation parks the parser in the error phase.
    if (bad) begin
      phase_next = PH_ERROR;
      ev   = EV_ERROR;
      num  = '0;
      pay  = 8'h00;
      last = 1'b0;
    end
  end

  assign res_flags.event_res    = ev;
  assign res_flags.last_payload = last;
  assign res_number  = num;
  assign res_payload = pay;
  assign res_index   = element_index_next;

  // Parse state advances once per word taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_ARR_LEAD;
      number_accum  <= '0;
      number_over   <= 1'b0;
      element_total <= '0;
      element_index <= '0;
      payload_left  <= '0;
    end else if (step) begin
      phase         <= phase_next;
      number_accum  <= number_accum_next;
      number_over   <= number_over_next;
      element_total <= element_total_next;
      element_index <= element_index_next;
      payload_left  <= payload_left_next;
    end
  end

endmodule

### rtl/core/resp_multibulk_parser.sv
// Top level of the RESP multibulk request parser: stream ports, input and result registers.
`timescale 1ns / 1ps

// The parser takes one request byte per word on the slave stream and returns exactly one
// event word per byte on the master stream, one byte per clock sustained while the output
// is not stalled. A byte passes an input register, the combinational phase update and a
// result register. Its event word is presented from the result register once the byte
// has stepped out of the input register, and is accepted when m_axis_tready is high. The
// event kind travels in m_axis_tuser and m_axis_tlast marks the final payload byte of a bulk
// string. After an error every byte yields an error event until reset. The user must write
// length_limit through cfg_we/cfg_wdata only while no byte is in flight; the block itself
// does not enforce it.
module resp_multibulk_parser import rmbp_pkg::*; #(
  parameter int NUMBER_WIDTH = 27
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration: length_limit.
  input  logic                    cfg_we,
  input  logic [NUMBER_WIDTH-1:0] cfg_wdata,
  // Input stream.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // data_byte
  // Output stream.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // number_value, payload_byte, string_index, zero fill
  output logic [((2 * NUMBER_WIDTH + 8 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [2:0]              m_axis_tuser,   // event_res
  output logic                    m_axis_tlast    // last_payload
);

  localparam int TDATA_BITS = 2 * NUMBER_WIDTH + 8;
  localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;
  localparam logic [NUMBER_WIDTH-1:0] LIMIT_RESET = NUMBER_WIDTH'(LIMIT_RESET_FULL);

  logic [NUMBER_WIDTH-1:0] length_limit;
  logic                    in_valid;
  logic [7:0]              in_byte;
  logic                    out_valid;
  res_flags_t              out_flags;
  logic [NUMBER_WIDTH-1:0] out_number;
  logic [7:0]              out_payload;
  logic [NUMBER_WIDTH-1:0] out_index;
  logic                    out_free;
  logic                    step;
  res_flags_t              res_flags;
  logic [NUMBER_WIDTH-1:0] res_number;
  logic [7:0]              res_payload;
  logic [NUMBER_WIDTH-1:0] res_index;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      length_limit <= cfg_wdata;
    end
  end

  // A word moves into the result register whenever that register is free or being drained.
  assign out_free      = !out_valid || m_axis_tready;
  assign step          = in_valid && out_free;
  assign s_axis_tready = !in_valid || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Phase update.
  rmbp_core #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .data_byte    (in_byte),
    .length_limit (length_limit),
    .res_flags    (res_flags),
    .res_number   (res_number),
    .res_payload  (res_payload),
    .res_index    (res_index)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_flags   <= res_flags;
      out_number  <= res_number;
      out_payload <= res_payload;
      out_index   <= res_index;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'({out_index, out_payload, out_number});
  assign m_axis_tuser  = out_flags.event_res;
  assign m_axis_tlast  = out_flags.last_payload;

  // A held input word must stay put until it is stepped.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_byte))
    else $error("input word lost or changed while waiting");

  // With the result register empty the input side must never stall.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled while the result register was empty");

  // The last-byte mark only ever comes with a payload byte event.
  a_last_is_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flags.last_payload |-> out_flags.event_res == EV_BYTE)
    else $error("last-byte mark on a non-payload event");

endmodule

### tb/testbench.sv
// Self-checking testbench for the RESP multibulk request parser.
`timescale 1ns / 1ps

module testbench;
  import rmbp_pkg::*;

  localparam int NW = 27;
  localparam int TDATA_W = ((2 * NW + 8 + 7) / 8) * 8;
  localparam logic [63:0] NUM_MASK = (64'd1 << NW) - 64'd1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DIR_ROWS = 24;
  localparam int PHASES = 6;

  // One expected event word, field by field.
  typedef struct packed {
    event_t          ev;
    logic [NW-1:0]   number;
    logic [7:0]      payload;
    logic [NW-1:0]   index;
    logic            last;
  } parse_result_t;

  // One row of the directed table: a byte and, where typed is set, its known event.
  typedef struct packed {
    logic [7:0]    data;
    logic          typed;
    parse_result_t want;
  } dir_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [NW-1:0]      cfg_wdata = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               m_axis_tlast;

  // Parser state as the testbench tracks it, starting from its reset values.
  phase_t        cur_phase = PH_ARR_LEAD;
  logic [NW-1:0] digits_value = '0;
  logic          digits_over = 1'b0;
  logic [NW-1:0] strings_total = '0;
  logic [NW-1:0] string_no = '0;
  logic [NW-1:0] payload_todo = '0;
  logic [NW-1:0] max_number = NW'(LIMIT_RESET_FULL);

  parse_result_t pending_events[$];
  int            mismatch_count = 0;
  int            words_sent = 0;
  bit            idle_on = 1'b1;
  bit            hold_req = 1'b0;

  resp_multibulk_parser #(
    .NUMBER_WIDTH(NW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the tracked parser state by one byte and return the event it yields.
  function automatic parse_result_t parse_event(input logic [7:0] b);
    parse_result_t r;
    logic          bad;
    logic          fits;
    logic [63:0]   grown;
    r = '0;
    bad = 1'b0;
    fits = !digits_over && (digits_value <= max_number);
    case (cur_phase)
      PH_ARR_LEAD: begin
        string_no = '0;
        if (b == CH_STAR) begin
          digits_value = '0;
          digits_over = 1'b0;
          cur_phase = PH_ARR_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ARR_NUM, PH_STR_NUM: begin
        if (b == CH_CR) begin
          cur_phase = (cur_phase == PH_ARR_NUM) ? PH_ARR_LF : PH_STR_LF;
        end else if (b < CH_ZERO || b > CH_NINE) begin
          bad = 1'b1;
        end else if (!digits_over) begin
          // Once the value would reach the decimal ceiling it freezes and is flagged.
          grown = 64'(digits_value) * 64'd10 + 64'(b - CH_ZERO);
          if (grown >= NUM_CEIL || grown > NUM_MASK) digits_over = 1'b1;
          else digits_value = grown[NW-1:0];
        end
      end
      PH_ARR_LF: begin
        if (b != CH_LF || !fits) begin
          bad = 1'b1;
        end else begin
          strings_total = digits_value;
          string_no = '0;
          if (strings_total == '0) begin
            r.ev = EV_MESSAGE;
            cur_phase = PH_ARR_LEAD;
          end else begin
            r.ev = EV_COUNT;
            r.number = strings_total;
            cur_phase = PH_STR_LEAD;
          end
        end
      end
      PH_STR_LEAD: begin
        if (b == CH_DOLLAR) begin
          digits_value = '0;
          digits_over = 1'b0;
          cur_phase = PH_STR_NUM;
        end else begin
          bad = 1'b1;
        end
      end
      PH_STR_LF: begin
        if (b != CH_LF || !fits) begin
          bad = 1'b1;
        end else begin
          payload_todo = digits_value;
          r.ev = EV_LENGTH;
          r.number = digits_value;
          cur_phase = (payload_todo == '0) ? PH_TAIL_CR : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r.ev = EV_BYTE;
        r.payload = b;
        r.last = (payload_todo <= 1);
        if (payload_todo != '0) payload_todo = payload_todo - 1'b1;
        if (payload_todo == '0) cur_phase = PH_TAIL_CR;
      end
      PH_TAIL_CR: begin
        if (b == CH_CR) cur_phase = PH_TAIL_LF;
        else bad = 1'b1;
      end
      PH_TAIL_LF: begin
        if (b != CH_LF) begin
          bad = 1'b1;
        end else if (64'(string_no) + 64'd1 >= 64'(strings_total)) begin
          // The last string closes the message and keeps its own index.
          r.ev = EV_MESSAGE;
          cur_phase = PH_ARR_LEAD;
        end else begin
          r.ev = EV_STRING;
          string_no = string_no + 1'b1;
          cur_phase = PH_STR_LEAD;
        end
      end
      default: bad = 1'b1;
    endcase
    // Any violation locks the parser into the error phase.
    if (bad) begin
      cur_phase = PH_ERROR;
      r = '0;
      r.ev = EV_ERROR;
    end
    r.index = string_no;
    return r;
  endfunction

  function automatic dir_row_t make_row(input logic [7:0] d, input logic typed,
                                        input event_t ev, input int num,
                                        input logic [7:0] pay, input int idx,
                                        input logic last);
    dir_row_t row;
    row.data = d;
    row.typed = typed;
    row.want.ev = ev;
    row.want.number = NW'(num);
    row.want.payload = pay;
    row.want.index = NW'(idx);
    row.want.last = last;
    return row;
  endfunction

  // A random size up to the current limit or the typical size, whichever is smaller, often right at it.
  function automatic int unsigned pick_size(input int unsigned typical);
    int unsigned hi;
    hi = (max_number < typical) ? max_number : typical;
    if ($urandom_range(3) == 0) return hi;
    return $urandom_range(hi);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // Offer one byte, with a random one-cycle gap first, and record its expected event once taken.
  task automatic send_word(input logic [7:0] b);
    if (idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_events.push_back(parse_event(b));
    words_sent++;
  endtask

  // Stop offering and wait until every expected event has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [NW-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    max_number = v;
    cfg_we <= 1'b0;
  endtask

  // Decimal digits of a count or length, sometimes with leading zeros or none at all for zero.
  task automatic send_number(input int unsigned n);
    string digits;
    if (n == 0 && $urandom_range(1) == 1) return;
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) send_word(CH_ZERO);
    digits = $sformatf("%0d", n);
    foreach (digits[i]) send_word(digits[i]);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_word(s[i]);
  endtask

  // One well-formed request with random sizes and random payload.
  task automatic send_message();
    int unsigned count;
    int unsigned len;
    logic [7:0]  data;
    count = pick_size(4);
    send_word(CH_STAR);
    send_number(count);
    send_word(CH_CR);
    send_word(CH_LF);
    for (int unsigned s = 0; s < count; s++) begin
      len = ($urandom_range(15) == 0) ? pick_size(40) : pick_size(6);
      send_word(CH_DOLLAR);
      send_number(len);
      send_word(CH_CR);
      send_word(CH_LF);
      for (int unsigned j = 0; j < len; j++) begin
        data = 8'($urandom_range(255));
        if ($urandom_range(7) == 0) data = ($urandom_range(1) == 1) ? CH_CR : CH_LF;
        send_word(data);
      end
      send_word(CH_CR);
      send_word(CH_LF);
    end
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 25);
      end
    end
  end

  // Compare each result word against the oldest expectation.
  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result word with no byte outstanding");
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser != want.ev)
          report_mismatch($sformatf("event %0d, want %0d", m_axis_tuser, want.ev));
        if (m_axis_tdata[NW-1:0] != want.number)
          report_mismatch($sformatf("number %0d, want %0d",
                                    m_axis_tdata[NW-1:0], want.number));
        if (m_axis_tdata[NW+7:NW] != want.payload)
          report_mismatch($sformatf("payload %h, want %h",
                                    m_axis_tdata[NW+7:NW], want.payload));
        if (m_axis_tdata[2*NW+7:NW+8] != want.index)
          report_mismatch($sformatf("string index %0d, want %0d",
                                    m_axis_tdata[2*NW+7:NW+8], want.index));
        if (m_axis_tlast != want.last)
          report_mismatch($sformatf("last flag %0b, want %0b", m_axis_tlast, want.last));
      end
    end
  end

  // Give up when neither side moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("** resp_multibulk_parser: FAILED **");
    $finish;
  end

  initial begin : stimulus
    dir_row_t      rows [DIR_ROWS];
    logic [NW-1:0] limits [PHASES];
    int            budget [PHASES];
    parse_result_t discard;
    int unsigned   kind;
    string         broken;
    int            phase_end;

    // Zero count with and without digits, then two strings: an empty one and a 0xFF byte.
    rows[0]  = make_row(CH_STAR,       1'b1, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[1]  = make_row(CH_ZERO,       1'b1, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[2]  = make_row(CH_CR,         1'b1, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[3]  = make_row(CH_LF,         1'b1, EV_MESSAGE, 0, 8'h00, 0, 1'b0);
    rows[4]  = make_row(CH_STAR,       1'b1, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[5]  = make_row(CH_CR,         1'b1, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[6]  = make_row(CH_LF,         1'b1, EV_MESSAGE, 0, 8'h00, 0, 1'b0);
    rows[7]  = make_row(CH_STAR,       1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[8]  = make_row(CH_ZERO + 8'd2, 1'b0, EV_NONE,   0, 8'h00, 0, 1'b0);
    rows[9]  = make_row(CH_CR,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[10] = make_row(CH_LF,         1'b1, EV_COUNT,   2, 8'h00, 0, 1'b0);
    rows[11] = make_row(CH_DOLLAR,     1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[12] = make_row(CH_ZERO,       1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[13] = make_row(CH_CR,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[14] = make_row(CH_LF,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[15] = make_row(CH_CR,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[16] = make_row(CH_LF,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[17] = make_row(CH_DOLLAR,     1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[18] = make_row(CH_ZERO + 8'd1, 1'b0, EV_NONE,   0, 8'h00, 0, 1'b0);
    rows[19] = make_row(CH_CR,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[20] = make_row(CH_LF,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[21] = make_row(8'hFF,         1'b1, EV_BYTE,    0, 8'hFF, 1, 1'b1);
    rows[22] = make_row(CH_CR,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);
    rows[23] = make_row(CH_LF,         1'b0, EV_NONE,    0, 8'h00, 0, 1'b0);

    limits[0] = NW'(99999999);
    limits[1] = '0;
    limits[2] = NW'(5);
    limits[3] = NW'(67108863);
    limits[4] = NW'($urandom_range(20, 1));
    limits[5] = NW'(99999999);
    budget[0] = 280;
    budget[1] = 40;
    budget[2] = 260;
    budget[3] = 300;
    budget[4] = 260;
    budget[5] = 260;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed rows replace the computed expectation with the known one.
    foreach (rows[i]) begin
      send_word(rows[i].data);
      if (rows[i].typed) begin
        discard = pending_events.pop_back();
        pending_events.push_back(rows[i].want);
      end
    end

    // Random well-formed requests under several limits.
    for (int p = 0; p < PHASES; p++) begin
      set_limit(limits[p]);
      idle_on = (p != 3);
      if (p == 0) hold_req = 1'b1;
      phase_end = words_sent + budget[p];
      while (words_sent < phase_end) begin
        send_message();
        if (p == 2 && $urandom_range(3) == 0) wait_drained();
      end
    end

    // The error phase is sticky, so one broken request, picked at random, ends the run.
    kind = $urandom_range(8);
    case (kind)
      0: broken = "x";
      1: broken = "*1a";
      2: broken = "*1\015X";
      3: broken = "*123456789\015\012";
      4: broken = "x";
      5: broken = "$1\015\012AB";
      6: broken = "$1\015\012A\015Z";
      7: broken = "$200000000\015\012";
      default: broken = "*4\015\012";
    endcase
    if (kind == 8) set_limit(NW'(3));
    if (kind >= 4 && kind <= 7) broken = {"*99999999\015\012$3\015\012abc\015\012", broken};
    send_text(broken);
    repeat (30) send_word(8'($urandom_range(255)));

    wait_drained();
    if (mismatch_count == 0) begin
      $display("** resp_multibulk_parser: PASSED **");
    end else begin
      $display("** resp_multibulk_parser: FAILED **");
    end
    $finish;
  end

endmodule
